/* hdl/clipped_rect_fill_engine_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the clipped rectangle fill engine
// Immediate-style wrappers around concurrent properties on clock and reset.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_RECT_FILL_ENGINE_UNIT_ASSERT_SVH
`define CLIPPED_RECT_FILL_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CRFE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define CRFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CRFE_ASSERT_IMPL(label, ante, cons)
`define CRFE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hdl/crfe_pkg.sv */
// ----------------------------------------------------------------------------
// crfe_pkg
// Shared types and constants of the clipped rectangle fill engine.
// ----------------------------------------------------------------------------
package crfe_pkg;

   // Field widths and defaults.
   localparam int CSR_DATA_W          = 12;
   localparam int CSR_INDEX_W         = 1;
   localparam int SCREEN_DIM_BITS_DEF = 12;
   localparam int DEFAULT_SCREEN_W    = 960;
   localparam int DEFAULT_SCREEN_H    = 720;
   localparam int RESET_SCREEN_W      = 640;
   localparam int RESET_SCREEN_H      = 480;
   localparam int COORD_W             = 18;
   localparam int RECT_W              = 16;
   localparam int PIXEL_INDEX_W       = 24;
   localparam int RGB_W               = 24;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   // Request commands.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Drawing modes; the unused code behaves as solid fill.
   localparam logic [1:0] MODE_SOLID   = 2'd0;
   localparam logic [1:0] MODE_PATTERN = 2'd1;
   localparam logic [1:0] MODE_OUTLINE = 2'd2;

   // Fill patterns.
   localparam logic [1:0] PAT_CHECKER  = 2'd0;
   localparam logic [1:0] PAT_EVEN_ROW = 2'd1;
   localparam logic [1:0] PAT_EVEN_GRID = 2'd2;
   localparam logic [1:0] PAT_NOT_ODD  = 2'd3;

   typedef enum logic [1:0] {
      ST_PIXEL   = 2'd0,
      ST_STARTED = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_IDLE    = 2'd3
   } status_type;

   typedef struct packed {
      logic                     cmd;
      logic signed [RECT_W-1:0] rect_x;
      logic signed [RECT_W-1:0] rect_y;
      logic signed [RECT_W-1:0] rect_w;
      logic signed [RECT_W-1:0] rect_h;
      logic [RGB_W-1:0]         fill_rgb;
      logic [1:0]               draw_mode;
      logic [1:0]               pattern_sel;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [PIXEL_INDEX_W-1:0] pixel_index;
      logic [RGB_W-1:0]         pixel_rgb;
      logic                     write_enable;
      logic                     last;
   } rsp_type;

endpackage

/* hdl/crfe_clip.sv */
// ----------------------------------------------------------------------------
// crfe_clip
// Clips one signed rectangle against the screen and reports the bounds.
// ----------------------------------------------------------------------------
module crfe_clip #(
   parameter int DIM_BITS = crfe_pkg::SCREEN_DIM_BITS_DEF
) (
   input  logic signed [crfe_pkg::COORD_W-1:0] x,
   input  logic signed [crfe_pkg::COORD_W-1:0] y,
   input  logic signed [crfe_pkg::COORD_W-1:0] w,
   input  logic signed [crfe_pkg::COORD_W-1:0] h,
   input  logic [DIM_BITS-1:0]                 screen_w,
   input  logic [DIM_BITS-1:0]                 screen_h,
   output logic                                hit,
   output logic [DIM_BITS-1:0]                 x0,
   output logic [DIM_BITS-1:0]                 y0,
   output logic [DIM_BITS-1:0]                 x1,
   output logic [DIM_BITS-1:0]                 y1
);
   import crfe_pkg::*;

   localparam int SUM_W = COORD_W + 1;

   logic signed [SUM_W-1:0] xs, ys, xe, ye, lim_w, lim_h;
   logic signed [SUM_W-1:0] cx0, cy0, cx1, cy1;

   // Edges in one extra bit so that x + w cannot wrap.
   assign xs    = {x[COORD_W-1], x};
   assign ys    = {y[COORD_W-1], y};
   assign xe    = xs + {w[COORD_W-1], w};
   assign ye    = ys + {h[COORD_W-1], h};
   assign lim_w = $signed({{(SUM_W-DIM_BITS){1'b0}}, screen_w});
   assign lim_h = $signed({{(SUM_W-DIM_BITS){1'b0}}, screen_h});

   // Clamp the near edges at zero and the far edges at the screen size.
   assign cx0 = xs[SUM_W-1] ? '0 : xs;
   assign cy0 = ys[SUM_W-1] ? '0 : ys;
   assign cx1 = (xe > lim_w) ? lim_w : xe;
   assign cy1 = (ye > lim_h) ? lim_h : ye;

   // Bounds are only meaningful when something is left on screen.
   assign hit = (cx0 < cx1) && (cy0 < cy1);
   assign x0  = cx0[DIM_BITS-1:0];
   assign y0  = cy0[DIM_BITS-1:0];
   assign x1  = cx1[DIM_BITS-1:0];
   assign y1  = cy1[DIM_BITS-1:0];

endmodule

/* hdl/clipped_rect_fill_engine_unit.sv */
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine_unit
// Rectangle fill and outline pixel generator for a framebuffer write port.
// ----------------------------------------------------------------------------
// Usage: a start request (cmd 0) carries the rectangle, color, mode and
// pattern, and is answered by one response: started or nothing to draw.
// Each step request (cmd 1) then returns one pixel of the clipped area in
// raster order, with last set on the final pixel; a step while idle returns
// the idle status. Outlines walk the top, bottom, left and right strips.
// Both channels use valid/ready. Every request yields exactly one response.
// An accepted request is held in the input register until the result slot
// frees, and the result register then captures its response. Throughput is
// one request per cycle while the receiver does not stall, because the clip
// compares and the row-times-width multiplier all settle combinationally
// between the two registers.
// When the receiver stalls, the result register holds its response and the
// input register still takes one more request before req_ready drops.
// The user must write screen size registers through the csr port while idle;
// the block does not enforce it. Reset clears both pipeline stages, the busy
// flag and sets the screen to 640 by 480.
// ----------------------------------------------------------------------------
`include "clipped_rect_fill_engine_unit_assert.svh"

module clipped_rect_fill_engine_unit #(
   parameter int SCREEN_DIM_BITS = crfe_pkg::SCREEN_DIM_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  crfe_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output crfe_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_en,
   input  logic [crfe_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [crfe_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import crfe_pkg::*;

   localparam int D       = SCREEN_DIM_BITS;
   localparam int DIM_MAX = (1 << D) - 1;
   localparam int DEF_W   = (DEFAULT_SCREEN_W > DIM_MAX) ? DIM_MAX : DEFAULT_SCREEN_W;
   localparam int DEF_H   = (DEFAULT_SCREEN_H > DIM_MAX) ? DIM_MAX : DEFAULT_SCREEN_H;
   localparam logic [D-1:0] DEF_W_V = D'(DEF_W);
   localparam logic [D-1:0] DEF_H_V = D'(DEF_H);
   localparam logic signed [COORD_W-1:0] ONE_C = COORD_W'(1);
   localparam int PROD_W  = 2 * D + 1;

   // Screen size registers.
   logic [CSR_DATA_W-1:0] screen_width_ff, screen_width_in;
   logic [CSR_DATA_W-1:0] screen_height_ff, screen_height_in;

   // Pipeline registers.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Operation state.
   logic                     busy_ff, busy_in;
   logic [1:0]               op_mode_ff, op_mode_in;
   logic [1:0]               op_pattern_ff, op_pattern_in;
   logic [RGB_W-1:0]         op_color_ff, op_color_in;
   logic signed [RECT_W-1:0] sv_x_ff, sv_x_in, sv_y_ff, sv_y_in;
   logic signed [RECT_W-1:0] sv_w_ff, sv_w_in, sv_h_ff, sv_h_in;
   logic [1:0]               strip_ff, strip_in;
   logic [D-1:0]             bx0_ff, bx0_in, by0_ff, by0_in;
   logic [D-1:0]             bx1_ff, bx1_in, by1_ff, by1_in;
   logic [D-1:0]             cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;

   // Combinational signals.
   logic                          s1_fire, req_fire, is_start, full_rect;
   logic [CSR_DATA_W+D-1:0]       width_ext, height_ext;
   logic [D-1:0]                  sw_eff, sh_eff;
   logic signed [COORD_W-1:0]     rx, ry, rw, rh;
   logic signed [COORD_W-1:0]     st_x [4];
   logic signed [COORD_W-1:0]     st_y [4];
   logic signed [COORD_W-1:0]     st_w [4];
   logic signed [COORD_W-1:0]     st_h [4];
   logic [3:0]                    clip_hit;
   logic [D-1:0]                  clip_x0 [4];
   logic [D-1:0]                  clip_y0 [4];
   logic [D-1:0]                  clip_x1 [4];
   logic [D-1:0]                  clip_y1 [4];
   logic [3:0]                    above, cand;
   logic [1:0]                    sel;
   logic                          any_strip, size_ok, start_ok, is_outline_req;
   logic [1:0]                    start_strip, load_idx;
   logic                          pix_we, row_end, strip_end, more, last_flag;
   logic [D:0]                    nx, ny;
   logic [2*D-1:0]                row_base;
   logic [PROD_W-1:0]             index_sum;
   logic [PROD_W+PIXEL_INDEX_W-1:0] index_ext;

   // Handshakes: the input register drains whenever the result slot frees.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Effective screen size: low bits of the register, zero picks the default.
   always_comb begin
      width_ext  = {{D{1'b0}}, screen_width_ff};
      height_ext = {{D{1'b0}}, screen_height_ff};
      sw_eff = (width_ext[D-1:0] == '0) ? DEF_W_V : width_ext[D-1:0];
      sh_eff = (height_ext[D-1:0] == '0) ? DEF_H_V : height_ext[D-1:0];
   end

   // Rectangle source: the new request on a start, the saved one otherwise.
   always_comb begin
      is_start       = (s1_data_ff.cmd == CMD_START);
      is_outline_req = (s1_data_ff.draw_mode == MODE_OUTLINE);
      full_rect      = is_start && !is_outline_req;
      if (is_start) begin
         rx = {{2{s1_data_ff.rect_x[RECT_W-1]}}, s1_data_ff.rect_x};
         ry = {{2{s1_data_ff.rect_y[RECT_W-1]}}, s1_data_ff.rect_y};
         rw = {{2{s1_data_ff.rect_w[RECT_W-1]}}, s1_data_ff.rect_w};
         rh = {{2{s1_data_ff.rect_h[RECT_W-1]}}, s1_data_ff.rect_h};
      end else begin
         rx = {{2{sv_x_ff[RECT_W-1]}}, sv_x_ff};
         ry = {{2{sv_y_ff[RECT_W-1]}}, sv_y_ff};
         rw = {{2{sv_w_ff[RECT_W-1]}}, sv_w_ff};
         rh = {{2{sv_h_ff[RECT_W-1]}}, sv_h_ff};
      end
      // Top strip doubles as the whole rectangle for fills.
      st_x[0] = rx;              st_y[0] = ry;
      st_w[0] = rw;              st_h[0] = full_rect ? rh : ONE_C;
      // Bottom strip.
      st_x[1] = rx;              st_y[1] = ry + rh - ONE_C;
      st_w[1] = rw;              st_h[1] = ONE_C;
      // Left strip.
      st_x[2] = rx;              st_y[2] = ry;
      st_w[2] = ONE_C;           st_h[2] = rh;
      // Right strip.
      st_x[3] = rx + rw - ONE_C; st_y[3] = ry;
      st_w[3] = ONE_C;           st_h[3] = rh;
   end

   // One clipper per strip, all evaluated in parallel.
   for (genvar g = 0; g < 4; g++) begin : g_clip
      crfe_clip #(
         .DIM_BITS (D)
      ) u_clip (
         .x        (st_x[g]),
         .y        (st_y[g]),
         .w        (st_w[g]),
         .h        (st_h[g]),
         .screen_w (sw_eff),
         .screen_h (sh_eff),
         .hit      (clip_hit[g]),
         .x0       (clip_x0[g]),
         .y0       (clip_y0[g]),
         .x1       (clip_x1[g]),
         .y1       (clip_y1[g])
      );
   end

   // First non-empty strip, from the top on a start, past the current one later.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         above[i] = (2'(i) > strip_ff);
      end
      cand      = clip_hit & (is_start ? 4'b1111 : above);
      any_strip = |cand;
      sel       = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (cand[i]) begin
            sel = 2'(i);
         end
      end
   end

   // Start outcome.
   always_comb begin
      size_ok     = (s1_data_ff.rect_w > 0) && (s1_data_ff.rect_h > 0);
      start_ok    = size_ok && (is_outline_req ? any_strip : clip_hit[0]);
      start_strip = is_outline_req ? sel : 2'd0;
      load_idx    = is_start ? start_strip : sel;
   end

   // Pixel step: pattern gate, cursor advance and linear index.
   always_comb begin
      pix_we = 1'b1;
      if (op_mode_ff == MODE_PATTERN) begin
         case (op_pattern_ff)
            PAT_EVEN_ROW:  pix_we = !cur_y_ff[0];
            PAT_EVEN_GRID: pix_we = !cur_x_ff[0] && !cur_y_ff[0];
            PAT_NOT_ODD:   pix_we = !(cur_x_ff[0] && cur_y_ff[0]);
            default:       pix_we = !(cur_x_ff[0] ^ cur_y_ff[0]);
         endcase
      end
      nx        = {1'b0, cur_x_ff} + 1'b1;
      ny        = {1'b0, cur_y_ff} + 1'b1;
      row_end   = (nx >= {1'b0, bx1_ff});
      strip_end = row_end && (ny >= {1'b0, by1_ff});
      more      = (op_mode_ff == MODE_OUTLINE) && any_strip;
      last_flag = strip_end && !more;
      row_base  = cur_y_ff * sw_eff;
      index_sum = {1'b0, row_base} + {{(D+1){1'b0}}, cur_x_ff};
      index_ext = {{PIXEL_INDEX_W{1'b0}}, index_sum};
   end

   // Next state of the operation and the result register.
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      s1_valid_in   = s1_valid_ff;
      s1_data_in    = s1_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      busy_in       = busy_ff;
      op_mode_in    = op_mode_ff;
      op_pattern_in = op_pattern_ff;
      op_color_in   = op_color_ff;
      sv_x_in       = sv_x_ff;
      sv_y_in       = sv_y_ff;
      sv_w_in       = sv_w_ff;
      sv_h_in       = sv_h_ff;
      strip_in      = strip_ff;
      bx0_in        = bx0_ff;
      by0_in        = by0_ff;
      bx1_in        = bx1_ff;
      by1_in        = by1_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;

      // Configuration writes.
      if (csr_write_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata;
            default:           screen_width_in  = screen_width_ff;
         endcase
      end

      // Input register.
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      // Result register drains on the receiver's ready.
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (is_start) begin
            // Start request: latch the operation and enter the first strip.
            rsp_data_in.status = start_ok ? ST_STARTED : ST_EMPTY;
            busy_in       = start_ok;
            op_mode_in    = s1_data_ff.draw_mode;
            op_pattern_in = s1_data_ff.pattern_sel;
            op_color_in   = s1_data_ff.fill_rgb;
            sv_x_in       = s1_data_ff.rect_x;
            sv_y_in       = s1_data_ff.rect_y;
            sv_w_in       = s1_data_ff.rect_w;
            sv_h_in       = s1_data_ff.rect_h;
            strip_in      = start_strip;
            if (start_ok) begin
               bx0_in   = clip_x0[load_idx];
               by0_in   = clip_y0[load_idx];
               bx1_in   = clip_x1[load_idx];
               by1_in   = clip_y1[load_idx];
               cur_x_in = clip_x0[load_idx];
               cur_y_in = clip_y0[load_idx];
            end
         end else if (!busy_ff) begin
            rsp_data_in.status = ST_IDLE;
         end else begin
            // Step request: emit the pixel under the cursor.
            rsp_data_in.status       = ST_PIXEL;
            rsp_data_in.pixel_index  = index_ext[PIXEL_INDEX_W-1:0];
            rsp_data_in.pixel_rgb    = op_color_ff;
            rsp_data_in.write_enable = pix_we;
            rsp_data_in.last         = last_flag;
            cur_x_in = nx[D-1:0];
            if (row_end) begin
               cur_x_in = bx0_ff;
               cur_y_in = ny[D-1:0];
               if (strip_end) begin
                  if (more) begin
                     strip_in = sel;
                     bx0_in   = clip_x0[load_idx];
                     by0_in   = clip_y0[load_idx];
                     bx1_in   = clip_x1[load_idx];
                     by1_in   = clip_y1[load_idx];
                     cur_x_in = clip_x0[load_idx];
                     cur_y_in = clip_y0[load_idx];
                  end else begin
                     busy_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= CSR_DATA_W'(RESET_SCREEN_W);
         screen_height_ff <= CSR_DATA_W'(RESET_SCREEN_H);
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         busy_ff          <= 1'b0;
         op_mode_ff       <= MODE_SOLID;
         strip_ff         <= 2'd0;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         busy_ff          <= busy_in;
         op_mode_ff       <= op_mode_in;
         strip_ff         <= strip_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_data_ff    <= s1_data_in;
      rsp_data_ff   <= rsp_data_in;
      op_pattern_ff <= op_pattern_in;
      op_color_ff   <= op_color_in;
      sv_x_ff       <= sv_x_in;
      sv_y_ff       <= sv_y_in;
      sv_w_ff       <= sv_w_in;
      sv_h_ff       <= sv_h_in;
      bx0_ff        <= bx0_in;
      by0_ff        <= by0_in;
      bx1_ff        <= bx1_in;
      by1_ff        <= by1_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
   end

   // The cursor never leaves the current strip while an operation runs.
   `CRFE_ASSERT_IMPL(a_cursor_x_in_box, busy_ff, (cur_x_ff >= bx0_ff) && (cur_x_ff < bx1_ff))
   `CRFE_ASSERT_IMPL(a_cursor_y_in_box, busy_ff, (cur_y_ff >= by0_ff) && (cur_y_ff < by1_ff))
   // Only outlines move past the first strip.
   `CRFE_ASSERT_IMPL(a_strip_fill, busy_ff && (op_mode_ff != MODE_OUTLINE), strip_ff == 2'd0)
   // Status responses never carry the last flag.
   `CRFE_ASSERT_IMPL(a_status_clean, rsp_valid && (rsp_data.status != ST_PIXEL), !rsp_data.last)
   // The last pixel ends the operation.
   `CRFE_ASSERT_NEXT(a_last_ends, s1_fire && !is_start && busy_ff && last_flag, !busy_ff)

endmodule

/* dv/tb_clipped_rect_fill_engine_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_clipped_rect_fill_engine_unit
// Drives start and step requests into the rectangle fill engine under random
// idling on both channels. It also runs the block at several screen sizes and
// holds the result channel off for a long stretch once. Each response is
// checked field by field against a raster walker kept inside the bench.
// ---------------------------------------------------------------------------
module tb_clipped_rect_fill_engine_unit;
   import crfe_pkg::*;

   localparam int SCREEN_DIM_BITS  = SCREEN_DIM_BITS_DEF;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_CYCLES = 160;
   localparam int WALK_CAP         = 400;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   // Screen registers as last written.
   logic [CSR_DATA_W-1:0] screen_w_reg = CSR_DATA_W'(RESET_SCREEN_W);
   logic [CSR_DATA_W-1:0] screen_h_reg = CSR_DATA_W'(RESET_SCREEN_H);

   // Raster walker state.
   bit         draw_busy;
   bit [1:0]   draw_mode_q;
   bit [1:0]   draw_pattern_q;
   bit [23:0]  draw_color;
   int         rect_left, rect_top, rect_wd, rect_ht;
   int         strip_sel;
   int         clip_x0, clip_y0, clip_x1, clip_y1;
   int         col, row;

   rsp_type    owed_responses[$];
   int         requests_sent;
   int         mismatches;
   int         cycles_run;

   // Idling controls shared between the request side and the result side.
   bit         sender_idle_on   = 1'b1;
   bit         receiver_idle_on = 1'b1;
   int         hold_request;
   int         hold_left;
   int         stall_left;

   clipped_rect_fill_engine_unit #(
      .SCREEN_DIM_BITS(SCREEN_DIM_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Effective screen dimension: zero picks the default, capped to the field.
   function automatic int screen_dim(logic [CSR_DATA_W-1:0] reg_val, int dflt);
      int lim;
      int dim;
      lim = (1 << SCREEN_DIM_BITS) - 1;
      dim = int'(reg_val) & lim;
      if (dim == 0) dim = dflt;
      if (dim > lim) dim = lim;
      return dim;
   endfunction

   // Clip a box to the screen and park the cursor on its first pixel.
   function automatic bit clip_area(int x, int y, int w, int h);
      int x0, y0, x1, y1;
      x0 = x;
      y0 = y;
      x1 = x + w;
      y1 = y + h;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > screen_dim(screen_w_reg, DEFAULT_SCREEN_W)) begin
         x1 = screen_dim(screen_w_reg, DEFAULT_SCREEN_W);
      end
      if (y1 > screen_dim(screen_h_reg, DEFAULT_SCREEN_H)) begin
         y1 = screen_dim(screen_h_reg, DEFAULT_SCREEN_H);
      end
      if (x0 >= x1 || y0 >= y1) return 1'b0;
      clip_x0 = x0;
      clip_y0 = y0;
      clip_x1 = x1;
      clip_y1 = y1;
      col     = x0;
      row     = y0;
      return 1'b1;
   endfunction

   // Outline strips in order top, bottom, left, right.
   function automatic bit enter_strip(int s);
      case (s)
         0: return clip_area(rect_left, rect_top, rect_wd, 1);
         1: return clip_area(rect_left, rect_top + rect_ht - 1, rect_wd, 1);
         2: return clip_area(rect_left, rect_top, 1, rect_ht);
         default: return clip_area(rect_left + rect_wd - 1, rect_top, 1, rect_ht);
      endcase
   endfunction

   // First strip from s on that still has pixels on screen.
   function automatic bit find_strip(int s);
      for (int k = s; k < 4; k++) begin
         if (enter_strip(k)) begin
            strip_sel = k;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Update the walker for one accepted request and return its response.
   function automatic rsp_type advance_engine(req_type r);
      rsp_type     e;
      bit          ok;
      bit          more;
      bit          odd_x, odd_y;
      int unsigned lin;
      e = '0;
      if (r.cmd == CMD_START) begin
         draw_busy      = 1'b0;
         draw_mode_q    = r.draw_mode;
         draw_pattern_q = r.pattern_sel;
         draw_color     = r.fill_rgb;
         rect_left      = int'(r.rect_x);
         rect_top       = int'(r.rect_y);
         rect_wd        = int'(r.rect_w);
         rect_ht        = int'(r.rect_h);
         strip_sel      = 0;
         if (rect_wd <= 0 || rect_ht <= 0) ok = 1'b0;
         else if (draw_mode_q == MODE_OUTLINE) ok = find_strip(0);
         else ok = clip_area(rect_left, rect_top, rect_wd, rect_ht);
         draw_busy = ok;
         if (ok) e.status = ST_STARTED;
         else e.status = ST_EMPTY;
      end else if (!draw_busy) begin
         e.status = ST_IDLE;
      end else begin
         odd_x = col[0];
         odd_y = row[0];
         e.write_enable = 1'b1;
         if (draw_mode_q == MODE_PATTERN) begin
            case (draw_pattern_q)
               PAT_EVEN_ROW:  e.write_enable = !odd_y;
               PAT_EVEN_GRID: e.write_enable = !odd_x && !odd_y;
               PAT_NOT_ODD:   e.write_enable = !(odd_x && odd_y);
               default:       e.write_enable = (odd_x == odd_y);
            endcase
         end
         // The index always follows the current screen width.
         lin = row * screen_dim(screen_w_reg, DEFAULT_SCREEN_W) + col;
         e.status      = ST_PIXEL;
         e.pixel_index = lin[23:0];
         e.pixel_rgb   = draw_color;
         col = col + 1;
         if (col >= clip_x1) begin
            col = clip_x0;
            row = row + 1;
            if (row >= clip_y1) begin
               more = 1'b0;
               if (draw_mode_q == MODE_OUTLINE) more = find_strip(strip_sel + 1);
               if (!more) begin
                  e.last    = 1'b1;
                  draw_busy = 1'b0;
               end
            end
         end
      end
      return e;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Result side: random stalls, an optional long hold-off, and the checks.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_responses.size() == 0) begin
            $error("response with no request outstanding, status %0d", rsp_data.status);
            mismatches++;
         end else begin
            want = owed_responses.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_data.status));
            compare_field("pixel_index", 32'(want.pixel_index), 32'(rsp_data.pixel_index));
            compare_field("pixel_rgb", 32'(want.pixel_rgb), 32'(rsp_data.pixel_rgb));
            compare_field("write_enable", 32'(want.write_enable),
                          32'(rsp_data.write_enable));
            compare_field("last", 32'(want.last), 32'(rsp_data.last));
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_request > 0) begin
         hold_left    = hold_request - 1;
         hold_request = 0;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (receiver_idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one request, wait for the handshake and record its response.
   task automatic send_request(req_type r);
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      owed_responses.push_back(advance_engine(r));
      requests_sent++;
   endtask

   // Stop offering, wait for every response and let the pipeline empty.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (owed_responses.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_screen(int w, int h);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SCREEN_WIDTH;
      csr_wdata    <= w[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index    <= CSR_SCREEN_HEIGHT;
      csr_wdata    <= h[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      screen_w_reg = w[CSR_DATA_W-1:0];
      screen_h_reg = h[CSR_DATA_W-1:0];
   endtask

   function automatic req_type make_start(int x, int y, int w, int h, logic [23:0] rgb,
                                          logic [1:0] mode, logic [1:0] pat);
      req_type r;
      r.cmd         = CMD_START;
      r.rect_x      = x[15:0];
      r.rect_y      = y[15:0];
      r.rect_w      = w[15:0];
      r.rect_h      = h[15:0];
      r.fill_rgb    = rgb;
      r.draw_mode   = mode;
      r.pattern_sel = pat;
      return r;
   endfunction

   // Step request; the rest of the payload is don't-care and gets noise.
   function automatic req_type make_step();
      req_type r;
      r = make_start($urandom, $urandom, $urandom, $urandom, 24'($urandom), 2'($urandom),
                     2'($urandom));
      r.cmd = CMD_STEP;
      return r;
   endfunction

   task automatic walk_pixels(int cap);
      for (int k = 0; k < cap && draw_busy; k++) send_request(make_step());
   endtask

   // Coordinate near the low edge, anywhere inside, or near the high edge.
   function automatic int near_edge(int span, int size);
      case ($urandom_range(0, 2))
         0: return int'($urandom_range(0, size + 4)) - size - 2;
         1: return int'($urandom_range(0, span - 1));
         default: return span + 1 - int'($urandom_range(0, size + 2));
      endcase
   endfunction

   // A small rectangle around the screen edges, walked to its end or cut short.
   task automatic draw_random_rect();
      int w, h, cut;
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 4) == 0) w = $urandom_range(1, 20);
      if ($urandom_range(0, 4) == 0) h = $urandom_range(1, 12);
      send_request(make_start(near_edge(screen_dim(screen_w_reg, DEFAULT_SCREEN_W), w),
                              near_edge(screen_dim(screen_h_reg, DEFAULT_SCREEN_H), h),
                              w, h, 24'($urandom), 2'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3))));
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, 5);
      else cut = WALK_CAP;
      walk_pixels(cut);
      repeat ($urandom_range(0, 1)) send_request(make_step());
   endtask

   // Stray steps, fully random starts and starts with a non-positive size.
   task automatic send_noise();
      req_type r;
      r = make_step();
      r.cmd = CMD_START;
      case ($urandom_range(0, 2))
         0: send_request(make_step());
         1: begin
            send_request(r);
            repeat ($urandom_range(0, 3)) send_request(make_step());
         end
         default: begin
            if ($urandom_range(0, 1) == 0) r.rect_w = RECT_W'(-int'($urandom_range(0, 32768)));
            else r.rect_h = RECT_W'(-int'($urandom_range(0, 32768)));
            send_request(r);
         end
      endcase
   endtask

   task automatic run_random_mix(int count);
      int target;
      target = requests_sent + count;
      while (requests_sent < target) begin
         if ($urandom_range(0, 9) < 8) draw_random_rect();
         else send_noise();
      end
   endtask

   // Idle step, then a two-pixel solid fill at the reset screen size.
   task automatic test_idle_and_small_fill();
      send_request(make_step());
      send_request(make_start(1, 1, 2, 1, 24'hFFFFFF, MODE_SOLID, PAT_CHECKER));
      walk_pixels(WALK_CAP);
      send_request(make_step());
   endtask

   // Zero and negative sizes and rectangles fully off screen.
   task automatic test_empty_rects();
      send_request(make_start(0, 0, 0, 5, 24'h000000, MODE_SOLID, PAT_CHECKER));
      send_request(make_start(0, 0, 32767, -32768, 24'h123456, MODE_PATTERN, PAT_EVEN_ROW));
      send_request(make_start(-100, 10, 50, 10, 24'hABCDEF, MODE_OUTLINE, PAT_NOT_ODD));
      send_request(make_start(32767, 32767, 32767, 32767, 24'h800001, MODE_SOLID,
                              PAT_EVEN_GRID));
      send_request(make_start(-32768, -32768, 1, 1, 24'h7FFFFE, MODE_SOLID, PAT_CHECKER));
      send_request(make_step());
   endtask

   // Pattern gating on odd coordinates, and the unused mode as solid fill.
   task automatic test_pattern_and_spare_mode();
      send_request(make_start(1, 1, 2, 2, 24'h00FF00, MODE_PATTERN, PAT_NOT_ODD));
      walk_pixels(WALK_CAP);
      send_request(make_start(0, 0, 1, 1, 24'h0000FF, 2'd3, PAT_EVEN_GRID));
      walk_pixels(WALK_CAP);
   endtask

   // A one-pixel outline in the far corner yields the same pixel four times.
   task automatic test_outline_corner();
      send_request(make_start(RESET_SCREEN_W - 1, RESET_SCREEN_H - 1, 1, 1, 24'hFF0000,
                              MODE_OUTLINE, PAT_CHECKER));
      walk_pixels(WALK_CAP);
   endtask

   // A new start while busy drops the running fill.
   task automatic test_restart_while_busy();
      send_request(make_start(0, 0, 50, 50, 24'h555555, MODE_SOLID, PAT_CHECKER));
      send_request(make_step());
      send_request(make_start(5, 5, 1, 1, 24'hAAAAAA, MODE_SOLID, PAT_CHECKER));
      walk_pixels(WALK_CAP);
   endtask

   // Random drawing across reset, default, largest, smallest and odd screens.
   task automatic test_random_screens();
      int w, h;
      for (int phase = 0; phase < 8; phase++) begin
         settle_pipeline();
         case (phase)
            0: begin w = RESET_SCREEN_W; h = RESET_SCREEN_H; end
            1: begin w = 0; h = 0; end
            2: begin w = 4095; h = 4095; end
            3: begin w = 1; h = 1; end
            4: begin w = 4095; h = 1; end
            5: begin w = 1; h = 4095; end
            6: begin w = $urandom_range(0, 4095); h = $urandom_range(0, 4095); end
            default: begin w = $urandom_range(2, 64); h = $urandom_range(2, 48); end
         endcase
         set_screen(w, h);
         sender_idle_on   = (phase % 3 != 2);
         receiver_idle_on = (phase % 4 != 3);
         run_random_mix(120);
      end
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   // Width changes between pixels of a running fill.
   task automatic test_resize_mid_draw();
      int h;
      for (int n = 0; n < 6; n++) begin
         settle_pipeline();
         h = $urandom_range(4, 30);
         set_screen($urandom_range(4, 40), h);
         send_request(make_start(int'($urandom_range(0, 3)) - 1, int'($urandom_range(0, 3)) - 1,
                                 $urandom_range(3, 10), $urandom_range(2, 6), 24'($urandom),
                                 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))));
         walk_pixels($urandom_range(1, 4));
         settle_pipeline();
         set_screen($urandom_range(4, 40), h);
         walk_pixels(WALK_CAP);
      end
   endtask

   // Long hold-off on results while steps keep coming, so the input stalls.
   task automatic test_result_backpressure();
      settle_pipeline();
      set_screen(RESET_SCREEN_W, RESET_SCREEN_H);
      sender_idle_on = 1'b0;
      send_request(make_start(0, 0, 200, 200, 24'($urandom), MODE_SOLID, PAT_CHECKER));
      hold_request = LONG_HOLD_CYCLES;
      repeat (40) send_request(make_step());
      settle_pipeline();
      sender_idle_on = 1'b1;
   endtask

   // Closing stretch at full rate with no idling on either side.
   task automatic test_full_rate();
      settle_pipeline();
      set_screen($urandom_range(8, 64), $urandom_range(8, 48));
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      run_random_mix(250);
   endtask

   initial begin
      for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_and_small_fill();
      test_empty_rects();
      test_pattern_and_spare_mode();
      test_outline_corner();
      test_restart_while_busy();
      test_random_screens();
      test_resize_mid_draw();
      test_result_backpressure();
      test_full_rate();
      settle_pipeline();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
